[hdl/srpt_pkg.sv]
// shared types and constants for the stride reference prediction table
package srpt_pkg;

  localparam int ADDR_W   = 64;
  localparam int STRIDE_W = 32;

  // per-entry prediction state, encoding fixed by the table format
  typedef enum logic [1:0] {
    PST_INIT      = 2'd0,
    PST_TRANSIENT = 2'd1,
    PST_STEADY    = 2'd2,
    PST_NOPRED    = 2'd3
  } pred_state_t;

  // one table entry; the tag is the full pc
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   tag;
    logic [ADDR_W-1:0]   last_addr;
    logic [STRIDE_W-1:0] stride;
    pred_state_t         state;
  } entry_t;

endpackage

[hdl/srpt_table_mem.sv]
// synchronous table memory, one write port and one registered read port
module srpt_table_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  srpt_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output srpt_pkg::entry_t rdata
);

  srpt_pkg::entry_t mem_r [DEPTH];
  srpt_pkg::entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/srpt_index.sv]
// table index unit: pc modulo the table size
module srpt_index #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [63:0]   pc,
  output logic          idx_valid,
  output logic [IW-1:0] idx
);

  localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

  generate
    if (IS_POW2) begin : g_pow2
      logic [IW-1:0] idx_r;
      logic          rdy_r;

      // low pc bits are the index
      always_ff @(posedge clk) begin
        if (load) begin
          idx_r <= pc[IW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rdy_r <= 1'b0;
        end else if (load) begin
          rdy_r <= 1'b1;
        end
      end

      assign idx_valid = rdy_r;
      assign idx       = idx_r;
    end else begin : g_rem
      localparam logic [IW:0] MODULUS = (IW+1)'(DEPTH);

      logic [63:0] sh_r;
      logic [IW:0] rem_r;
      logic [IW:0] rem_nxt;
      logic [2:0]  cnt_r;
      logic        busy_r;
      logic        done_r;

      // restoring reduction, eight pc bits per cycle
      always_comb begin
        rem_nxt = rem_r;
        for (int k = 0; k < 8; k++) begin
          rem_nxt = {rem_nxt[IW-1:0], sh_r[63-k]};
          if (rem_nxt >= MODULUS) begin
            rem_nxt = rem_nxt - MODULUS;
          end
        end
      end

      // datapath
      always_ff @(posedge clk) begin
        if (load) begin
          sh_r  <= pc;
          rem_r <= '0;
        end else if (busy_r) begin
          sh_r  <= {sh_r[55:0], 8'h00};
          rem_r <= rem_nxt;
        end
      end

      // step control
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r  <= '0;
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else if (load) begin
          cnt_r  <= '0;
          busy_r <= 1'b1;
          done_r <= 1'b0;
        end else if (busy_r) begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end

      assign idx_valid = done_r;
      assign idx       = rem_r[IW-1:0];
    end
  endgenerate

endmodule

[hdl/srpt_update.sv]
// entry update rules and prefetch address generation
module srpt_update (
  input  srpt_pkg::entry_t                cur,
  input  logic [srpt_pkg::ADDR_W-1:0]     pc,
  input  logic [srpt_pkg::ADDR_W-1:0]     addr,
  output srpt_pkg::entry_t                upd,
  output logic                            emit,
  output logic [srpt_pkg::ADDR_W-1:0]     pf_addr
);

  logic                          hit;
  logic [srpt_pkg::ADDR_W-1:0]   diff;
  logic [srpt_pkg::ADDR_W-1:0]   stride_x;
  logic                          match;

  assign hit      = cur.valid && (cur.tag == pc);
  assign diff     = addr - cur.last_addr;
  assign stride_x = {{(srpt_pkg::ADDR_W-srpt_pkg::STRIDE_W){cur.stride[srpt_pkg::STRIDE_W-1]}},
                     cur.stride};
  assign match    = (stride_x == diff);
  // a steady result always comes from a match, so the old stride is the one used
  assign pf_addr  = addr + stride_x;

  // rpt state transitions
  always_comb begin
    upd           = cur;
    upd.valid     = 1'b1;
    upd.tag       = pc;
    upd.last_addr = addr;
    if (!hit) begin
      upd.stride = '0;
      upd.state  = srpt_pkg::PST_INIT;
    end else if (match) begin
      upd.state = (cur.state == srpt_pkg::PST_NOPRED) ? srpt_pkg::PST_TRANSIENT
                                                      : srpt_pkg::PST_STEADY;
    end else begin
      unique case (cur.state)
        srpt_pkg::PST_INIT: begin
          upd.stride = diff[srpt_pkg::STRIDE_W-1:0];
          upd.state  = srpt_pkg::PST_TRANSIENT;
        end
        srpt_pkg::PST_TRANSIENT: begin
          upd.stride = diff[srpt_pkg::STRIDE_W-1:0];
          upd.state  = srpt_pkg::PST_NOPRED;
        end
        srpt_pkg::PST_STEADY: begin
          upd.state = srpt_pkg::PST_INIT;
        end
        default: begin
          upd.stride = diff[srpt_pkg::STRIDE_W-1:0];
          upd.state  = srpt_pkg::PST_NOPRED;
        end
      endcase
    end
  end

  assign emit = (upd.state == srpt_pkg::PST_STEADY);

endmodule

[hdl/stride_reference_prediction_table_unit.sv]
// Stride RPT prefetcher: index, table read, update and write-back per access.
// Each access passes the S_INDEX state (for non-power-of-two table sizes, a pc
// modulo reduction), a registered table read in S_LOOKUP, then the update, write-back
// and output register. Each access is indexed, read and written back before the next
// is taken, and a stalled result holds back an access that produces the next one.
// Reset: synchronous; a clearing pass invalidates every table entry, and no access
// is taken until it finishes.
module stride_reference_prediction_table_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_access_pc,
  input  logic [63:0] in_access_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_prefetch_address
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_INDEX  = 4'b0100,
    S_LOOKUP = 4'b1000
  } fsm_t;

  fsm_t             state_r, state_nxt;
  logic [IW-1:0]    clr_r;
  logic [IW-1:0]    idx_r;
  logic [63:0]      pc_r;
  logic [63:0]      addr_r;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_addr_r;

  logic             accept;
  logic             idx_valid;
  logic [IW-1:0]    idx;
  logic             rd_en;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  srpt_pkg::entry_t wr_data;
  srpt_pkg::entry_t rd_data;
  srpt_pkg::entry_t upd;
  logic             emit;
  logic [63:0]      pf_addr;
  logic             finish;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign rd_en  = (state_r == S_INDEX) && idx_valid;
  // a result may only enter a free or draining output register
  assign finish = (state_r == S_LOOKUP) && (!emit || !out_valid_r || !out_stall);

  srpt_index #(
    .DEPTH (TABLE_ENTRIES),
    .IW    (IW)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .pc        (in_access_pc),
    .idx_valid (idx_valid),
    .idx       (idx)
  );

  srpt_table_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (idx),
    .rdata (rd_data)
  );

  srpt_update u_update (
    .cur     (rd_data),
    .pc      (pc_r),
    .addr    (addr_r),
    .upd     (upd),
    .emit    (emit),
    .pf_addr (pf_addr)
  );

  // write port: clearing pass or entry write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = upd;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (finish) begin
      wr_en = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == IW'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = S_INDEX;
      S_INDEX:  if (idx_valid) state_nxt = S_LOOKUP;
      S_LOOKUP: if (finish) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + IW'(1);
      end
    end
  end

  // access payload and table index capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r   <= in_access_pc;
      addr_r <= in_access_address;
    end
    if (rd_en) begin
      idx_r <= idx;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (finish && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && emit) begin
      out_addr_r <= pf_addr;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_prefetch_address = out_addr_r;

endmodule

[hdl/srpt_checker.sv]
// port-level checker for the stride rpt unit, with its bind
module srpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_prefetch_address
);

  // reset leaves no result and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("result or input transfer possible right after reset");

  // one access at a time: busy in the cycle after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while the previous access is in flight");

  // a new result is produced only by an access that was being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an access in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_prefetch_address)))
    else $error("stalled result changed or was dropped");

endmodule

bind stride_reference_prediction_table_unit srpt_checker u_srpt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_prefetch_address (out_prefetch_address)
);
